### design/idf_pkg.sv
package idf_pkg;

   // field limits
   localparam int MAX_FIELD  = 40;
   localparam int LEN_W      = $clog2(MAX_FIELD + 2);

   // binary to decimal conversion
   localparam int VAL_W      = 64;
   localparam int BCD_DIGITS = 20;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int DIG_W      = $clog2(BCD_DIGITS + 1);
   localparam int BIT_CNT_W  = $clog2(VAL_W);

   // size codes
   localparam logic [2:0] SIZE_INT   = 3'd0;
   localparam logic [2:0] SIZE_CHAR  = 3'd1;
   localparam logic [2:0] SIZE_SHORT = 3'd2;

   // flag bit positions
   localparam int FLAG_SPACE_BIT = 2;
   localparam int FLAG_ZERO_BIT  = 3;
   localparam int FLAG_PLUS_BIT  = 4;
   localparam int FLAG_LEFT_BIT  = 5;

   // characters
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_PLAN,
      ST_EMIT
   } top_state_type;

   typedef enum logic [1:0] {
      BCD_IDLE,
      BCD_SHIFT,
      BCD_SCAN,
      BCD_HOLD
   } bcd_state_type;

   // character positions are region ends: pos below padl_end is left padding, etc.
   typedef struct packed {
      logic [LEN_W-1:0] padl_end;
      logic [LEN_W-1:0] sign_end;
      logic [LEN_W-1:0] zero_end;
      logic [LEN_W-1:0] digit_end;
      logic [LEN_W-1:0] length;
      logic [7:0]       sign_char;
   } idf_plan_type;

endpackage

### design/idf_bcd.sv
module idf_bcd (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [idf_pkg::VAL_W-1:0]       magnitude,
   input  logic                            digit_shift,
   output logic                            ready,
   output logic [idf_pkg::DIG_W-1:0]       ndig,
   output logic [3:0]                      top_digit
);

   idf_pkg::bcd_state_type               state_ff, state_in;
   logic [idf_pkg::VAL_W-1:0]            bin_ff, bin_in;
   logic [idf_pkg::BCD_W-1:0]            bcd_ff, bcd_in;
   logic [idf_pkg::BCD_W-1:0]            bcd_adj;
   logic [idf_pkg::BIT_CNT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [idf_pkg::DIG_W-1:0]            ndig_ff, ndig_in;

   // add 3 to every digit of five or more before each shift
   always_comb begin
      for (int d = 0; d < idf_pkg::BCD_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idf_pkg::BCD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      ndig_ff    <= ndig_in;
   end

   always_comb begin
      state_in   = state_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      ndig_in    = ndig_ff;
      case (state_ff)
         idf_pkg::BCD_SHIFT: begin
            bcd_in     = {bcd_adj[idf_pkg::BCD_W-2:0], bin_ff[idf_pkg::VAL_W-1]};
            bin_in     = {bin_ff[idf_pkg::VAL_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + idf_pkg::BIT_CNT_W'(1);
            if (bit_cnt_ff == idf_pkg::BIT_CNT_W'(idf_pkg::VAL_W - 1)) begin
               ndig_in  = idf_pkg::DIG_W'(idf_pkg::BCD_DIGITS);
               state_in = idf_pkg::BCD_SCAN;
            end
         end
         idf_pkg::BCD_SCAN: begin
            // drop leading zero digits, keep at least one
            if (ndig_ff > idf_pkg::DIG_W'(1) && bcd_ff[idf_pkg::BCD_W-1 -: 4] == 4'd0) begin
               bcd_in  = {bcd_ff[idf_pkg::BCD_W-5:0], 4'd0};
               ndig_in = ndig_ff - idf_pkg::DIG_W'(1);
            end else begin
               state_in = idf_pkg::BCD_HOLD;
            end
         end
         idf_pkg::BCD_HOLD: begin
            if (digit_shift) begin
               bcd_in = {bcd_ff[idf_pkg::BCD_W-5:0], 4'd0};
            end
         end
         default: begin
         end
      endcase
      if (start) begin
         bin_in     = magnitude;
         bcd_in     = '0;
         bit_cnt_in = '0;
         state_in   = idf_pkg::BCD_SHIFT;
      end
   end

   assign ready     = (state_ff == idf_pkg::BCD_HOLD);
   assign ndig      = ndig_ff;
   assign top_digit = bcd_ff[idf_pkg::BCD_W-1 -: 4];

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      !(start && (state_ff == idf_pkg::BCD_SHIFT || state_ff == idf_pkg::BCD_SCAN)))
      else $error("conversion restarted while busy");

   a_scan_ndig_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == idf_pkg::BCD_SCAN) |->
         (ndig_ff >= idf_pkg::DIG_W'(1) && ndig_ff <= idf_pkg::DIG_W'(idf_pkg::BCD_DIGITS)))
      else $error("digit count out of range during scan");

endmodule

### design/idf_emit.sv
module idf_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  idf_pkg::idf_plan_type plan,
   input  logic [3:0]           digit,
   output logic                 digit_shift,
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_last_char
);

   idf_pkg::idf_plan_type         plan_ff, plan_in;
   logic                          active_ff, active_in;
   logic [idf_pkg::LEN_W-1:0]     pos_ff, pos_in;
   logic [idf_pkg::LEN_W-1:0]     pos_next;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_char_ff, rsp_char_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          load;
   logic [7:0]                    next_char;
   logic                          is_last;

   assign load     = active_ff && (!rsp_valid_ff || !rsp_stall);
   assign pos_next = pos_ff + idf_pkg::LEN_W'(1);
   assign is_last  = (pos_next == plan_ff.length);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      plan_ff     <= plan_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      digit_shift = 1'b0;
      if (pos_ff < plan_ff.padl_end) begin
         next_char = idf_pkg::CHAR_SPACE;
      end else if (pos_ff < plan_ff.sign_end) begin
         next_char = plan_ff.sign_char;
      end else if (pos_ff < plan_ff.zero_end) begin
         next_char = idf_pkg::CHAR_ZERO;
      end else if (pos_ff < plan_ff.digit_end) begin
         next_char   = idf_pkg::CHAR_ZERO | {4'd0, digit};
         digit_shift = load;
      end else begin
         next_char = idf_pkg::CHAR_SPACE;
      end
   end

   always_comb begin
      plan_in      = plan_ff;
      active_in    = active_ff;
      pos_in       = pos_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = next_char;
         rsp_last_in  = is_last;
         pos_in       = pos_next;
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      if (start) begin
         plan_in   = plan;
         pos_in    = '0;
         active_in = (plan.length != '0);
      end
   end

   assign busy          = active_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   a_pos_in_field: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (pos_ff < plan_ff.length))
      else $error("character position beyond field length");

   a_last_ends_field: assert property (@(posedge clock) disable iff (reset)
      (load && is_last) |=> !active_ff)
      else $error("emitter still active after last character");

endmodule

### design/integer_decimal_field_formatter_top.sv
// A request is taken in the cycle it arrives when idle; the first character is then offered
// after 64 binary-to-decimal steps, 1 to 20 leading-digit scan steps, a hand-over, the
// layout state and one output register.
// One request is handled at a time, through the single bit-serial converter; characters
// then stream at one per cycle while the output does not stall.
// Reset: synchronous, active high; clears all control state, payload registers keep junk.
module integer_decimal_field_formatter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [63:0]       req_raw_value,
   input  logic              req_is_signed,
   input  logic [2:0]        req_size_code,
   input  logic [5:0]        req_field_width,
   input  logic signed [6:0] req_precision,
   input  logic [5:0]        req_format_flags,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last_char
);

   idf_pkg::top_state_type          state_ff, state_in;

   // captured request, already saturated
   logic [idf_pkg::LEN_W-1:0]       width_ff, width_in;
   logic [idf_pkg::LEN_W-1:0]       prec_ff, prec_in;
   logic                            has_prec_ff, has_prec_in;
   logic                            has_sign_ff, has_sign_in;
   logic [7:0]                      sign_char_ff, sign_char_in;
   logic                            mag_zero_ff, mag_zero_in;
   logic                            zero_flag_ff, zero_flag_in;
   logic                            left_flag_ff, left_flag_in;

   logic                            req_xfer;
   logic [idf_pkg::VAL_W-1:0]       trunc_val;
   logic [idf_pkg::VAL_W-1:0]       sext_val;
   logic                            top_bit;
   logic                            negative;
   logic [idf_pkg::VAL_W-1:0]       magnitude;

   logic                            bcd_ready;
   logic [idf_pkg::DIG_W-1:0]       bcd_ndig;
   logic [3:0]                      bcd_digit;
   logic                            digit_shift;
   logic                            emit_start;
   logic                            emit_busy;
   idf_pkg::idf_plan_type           plan;

   logic [idf_pkg::LEN_W-1:0]       ndig_eff;
   logic [idf_pkg::LEN_W-1:0]       prec_zeros;
   logic [idf_pkg::LEN_W-1:0]       body_len;
   logic [idf_pkg::LEN_W-1:0]       fill;
   logic                            fill_zero;
   logic [idf_pkg::LEN_W-1:0]       zeros_all;
   logic [idf_pkg::LEN_W-1:0]       pad;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != idf_pkg::ST_IDLE);

   // cut the argument to its C size and find the sign bit of that size
   always_comb begin
      case (req_size_code)
         idf_pkg::SIZE_INT: begin
            trunc_val = {32'd0, req_raw_value[31:0]};
            sext_val  = {{32{req_raw_value[31]}}, req_raw_value[31:0]};
            top_bit   = req_raw_value[31];
         end
         idf_pkg::SIZE_CHAR: begin
            trunc_val = {56'd0, req_raw_value[7:0]};
            sext_val  = {{56{req_raw_value[7]}}, req_raw_value[7:0]};
            top_bit   = req_raw_value[7];
         end
         idf_pkg::SIZE_SHORT: begin
            trunc_val = {48'd0, req_raw_value[15:0]};
            sext_val  = {{48{req_raw_value[15]}}, req_raw_value[15:0]};
            top_bit   = req_raw_value[15];
         end
         default: begin
            trunc_val = req_raw_value;
            sext_val  = req_raw_value;
            top_bit   = req_raw_value[63];
         end
      endcase
   end

   // negate the sign-extended value: gives 2^n - raw, exact even for the most negative value
   assign negative  = req_is_signed && top_bit;
   assign magnitude = negative ? (~sext_val + idf_pkg::VAL_W'(1)) : trunc_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      width_ff     <= width_in;
      prec_ff      <= prec_in;
      has_prec_ff  <= has_prec_in;
      has_sign_ff  <= has_sign_in;
      sign_char_ff <= sign_char_in;
      mag_zero_ff  <= mag_zero_in;
      zero_flag_ff <= zero_flag_in;
      left_flag_ff <= left_flag_in;
   end

   // capture the request on its transfer
   always_comb begin
      width_in     = width_ff;
      prec_in      = prec_ff;
      has_prec_in  = has_prec_ff;
      has_sign_in  = has_sign_ff;
      sign_char_in = sign_char_ff;
      mag_zero_in  = mag_zero_ff;
      zero_flag_in = zero_flag_ff;
      left_flag_in = left_flag_ff;
      if (req_xfer) begin
         if (req_field_width > 6'(idf_pkg::MAX_FIELD)) begin
            width_in = idf_pkg::LEN_W'(idf_pkg::MAX_FIELD);
         end else begin
            width_in = idf_pkg::LEN_W'(req_field_width);
         end
         // any negative precision means none given
         has_prec_in = !req_precision[6];
         if (req_precision[6]) begin
            prec_in = '0;
         end else if (req_precision[5:0] > 6'(idf_pkg::MAX_FIELD)) begin
            prec_in = idf_pkg::LEN_W'(idf_pkg::MAX_FIELD);
         end else begin
            prec_in = idf_pkg::LEN_W'(req_precision[5:0]);
         end
         has_sign_in  = 1'b0;
         sign_char_in = idf_pkg::CHAR_SPACE;
         if (req_is_signed) begin
            if (negative) begin
               has_sign_in  = 1'b1;
               sign_char_in = idf_pkg::CHAR_MINUS;
            end else if (req_format_flags[idf_pkg::FLAG_PLUS_BIT]) begin
               has_sign_in  = 1'b1;
               sign_char_in = idf_pkg::CHAR_PLUS;
            end else if (req_format_flags[idf_pkg::FLAG_SPACE_BIT]) begin
               has_sign_in  = 1'b1;
               sign_char_in = idf_pkg::CHAR_SPACE;
            end
         end
         mag_zero_in  = (trunc_val == '0);
         zero_flag_in = req_format_flags[idf_pkg::FLAG_ZERO_BIT];
         left_flag_in = req_format_flags[idf_pkg::FLAG_LEFT_BIT];
      end
   end

   // field layout from digit count, precision, sign and width
   always_comb begin
      if (mag_zero_ff && has_prec_ff && prec_ff == '0) begin
         ndig_eff = '0;
      end else begin
         ndig_eff = idf_pkg::LEN_W'(bcd_ndig);
      end
      prec_zeros = (prec_ff > ndig_eff) ? (prec_ff - ndig_eff) : '0;
      body_len   = ndig_eff + prec_zeros + idf_pkg::LEN_W'(has_sign_ff);
      fill       = (width_ff > body_len) ? (width_ff - body_len) : '0;
      // zero flag still applies with a precision, but never with left align
      fill_zero  = zero_flag_ff && !left_flag_ff;
      zeros_all  = prec_zeros + (fill_zero ? fill : '0);
      pad        = fill_zero ? '0 : fill;

      plan.padl_end  = left_flag_ff ? '0 : pad;
      plan.sign_end  = plan.padl_end + idf_pkg::LEN_W'(has_sign_ff);
      plan.zero_end  = plan.sign_end + zeros_all;
      plan.digit_end = plan.zero_end + ndig_eff;
      plan.length    = plan.digit_end + (left_flag_ff ? pad : '0);
      plan.sign_char = sign_char_ff;
   end

   // sequence: capture, convert, lay out, stream
   always_comb begin
      state_in   = state_ff;
      emit_start = 1'b0;
      case (state_ff)
         idf_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = idf_pkg::ST_CONV;
            end
         end
         idf_pkg::ST_CONV: begin
            if (bcd_ready) begin
               state_in = idf_pkg::ST_PLAN;
            end
         end
         idf_pkg::ST_PLAN: begin
            emit_start = 1'b1;
            state_in   = idf_pkg::ST_EMIT;
         end
         idf_pkg::ST_EMIT: begin
            // the last character may still wait in the output register
            if (!emit_busy) begin
               state_in = idf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = idf_pkg::ST_IDLE;
         end
      endcase
   end

   idf_bcd u_bcd (
      .clock       (clock),
      .reset       (reset),
      .start       (req_xfer),
      .magnitude   (magnitude),
      .digit_shift (digit_shift),
      .ready       (bcd_ready),
      .ndig        (bcd_ndig),
      .top_digit   (bcd_digit)
   );

   idf_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .start         (emit_start),
      .plan          (plan),
      .digit         (bcd_digit),
      .digit_shift   (digit_shift),
      .busy          (emit_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   a_shift_needs_digits: assert property (@(posedge clock) disable iff (reset)
      digit_shift |-> bcd_ready)
      else $error("digit taken before conversion finished");

   a_emit_only_in_emit: assert property (@(posedge clock) disable iff (reset)
      emit_busy |-> (state_ff == idf_pkg::ST_EMIT))
      else $error("emitter busy outside the streaming phase");

endmodule

### bench/idf_field_checker.sv
module idf_field_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [63:0]       req_raw_value,
   input  logic              req_is_signed,
   input  logic [2:0]        req_size_code,
   input  logic [5:0]        req_field_width,
   input  logic signed [6:0] req_precision,
   input  logic [5:0]        req_format_flags,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [7:0]        rsp_out_char,
   input  logic              rsp_last_char,
   output int                char_mismatches,
   output int                chars_pending
);

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } field_char_type;

   field_char_type expected_chars[$];

   function automatic void push_field_char(input logic [7:0] ch);
      field_char_type entry;
      entry.ch   = ch;
      entry.last = 1'b0;
      expected_chars.push_back(entry);
   endfunction

   // Lay out one conversion in the style of printf and queue its characters.
   function automatic void format_field_chars(
      input logic [63:0]       raw_value,
      input logic              is_signed,
      input logic [2:0]        size_code,
      input logic [5:0]        field_width,
      input logic signed [6:0] precision,
      input logic [5:0]        flags
   );
      logic [63:0] value;
      logic [63:0] magnitude;
      logic [63:0] top_bit;
      logic [63:0] rest;
      logic [7:0]  digit_chars [20];
      logic [7:0]  sign_char;
      logic        has_sign;
      logic        has_prec;
      logic        left;
      int          width;
      int          prec;
      int          ndig;
      int          zeros;
      int          total;
      int          pad;
      int          count;

      width    = field_width;
      has_prec = !precision[6];
      prec     = has_prec ? int'(precision[5:0]) : 0;
      if (width > idf_pkg::MAX_FIELD) width = idf_pkg::MAX_FIELD;
      if (prec > idf_pkg::MAX_FIELD) prec = idf_pkg::MAX_FIELD;
      left = flags[idf_pkg::FLAG_LEFT_BIT];

      value = raw_value;
      if (size_code == idf_pkg::SIZE_INT) value = value & 64'h0000_0000_FFFF_FFFF;
      else if (size_code == idf_pkg::SIZE_CHAR) value = value & 64'h0000_0000_0000_00FF;
      else if (size_code == idf_pkg::SIZE_SHORT) value = value & 64'h0000_0000_0000_FFFF;

      magnitude = value;
      has_sign  = 1'b0;
      sign_char = idf_pkg::CHAR_SPACE;
      if (is_signed) begin
         if (size_code == idf_pkg::SIZE_INT) top_bit = 64'h0000_0000_8000_0000;
         else if (size_code == idf_pkg::SIZE_CHAR) top_bit = 64'h0000_0000_0000_0080;
         else if (size_code == idf_pkg::SIZE_SHORT) top_bit = 64'h0000_0000_0000_8000;
         else top_bit = 64'h8000_0000_0000_0000;
         if ((value & top_bit) != 64'd0) begin
            // wraps to the two's complement for the 64-bit sizes
            magnitude = (top_bit << 1) - value;
            has_sign  = 1'b1;
            sign_char = idf_pkg::CHAR_MINUS;
         end else if (flags[idf_pkg::FLAG_PLUS_BIT]) begin
            has_sign  = 1'b1;
            sign_char = idf_pkg::CHAR_PLUS;
         end else if (flags[idf_pkg::FLAG_SPACE_BIT]) begin
            has_sign  = 1'b1;
            sign_char = idf_pkg::CHAR_SPACE;
         end
      end

      ndig = 0;
      if (!(magnitude == 64'd0 && has_prec && prec == 0)) begin
         rest = magnitude;
         do begin
            digit_chars[ndig] = idf_pkg::CHAR_ZERO + 8'(rest % 64'd10);
            rest = rest / 64'd10;
            ndig++;
         end while (rest != 64'd0 && ndig < 20);
      end

      zeros = (prec > ndig) ? prec - ndig : 0;
      total = ndig + zeros + (has_sign ? 1 : 0);
      pad   = 0;
      if (width > total) begin
         if (flags[idf_pkg::FLAG_ZERO_BIT] && !left) zeros += width - total;
         else pad = width - total;
      end

      count = 0;
      if (!left)
         for (int i = 0; i < pad; i++) begin
            push_field_char(idf_pkg::CHAR_SPACE);
            count++;
         end
      if (has_sign) begin
         push_field_char(sign_char);
         count++;
      end
      for (int i = 0; i < zeros; i++) begin
         push_field_char(idf_pkg::CHAR_ZERO);
         count++;
      end
      for (int i = ndig; i > 0; i--) begin
         push_field_char(digit_chars[i-1]);
         count++;
      end
      if (left)
         for (int i = 0; i < pad; i++) begin
            push_field_char(idf_pkg::CHAR_SPACE);
            count++;
         end
      if (count > 0) expected_chars[expected_chars.size()-1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      field_char_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               char_mismatches++;
               if (char_mismatches <= 10)
                  $display("unexpected character %h last %b", rsp_out_char, rsp_last_char);
            end else begin
               want = expected_chars.pop_front();
               if (want.ch !== rsp_out_char || want.last !== rsp_last_char) begin
                  char_mismatches++;
                  if (char_mismatches <= 10)
                     $display("character expected %h last %b, got %h last %b",
                              want.ch, want.last, rsp_out_char, rsp_last_char);
               end
            end
         end
         if (req_valid && !req_stall)
            format_field_chars(req_raw_value, req_is_signed, req_size_code,
                               req_field_width, req_precision, req_format_flags);
      end
      chars_pending = expected_chars.size();
   end

endmodule

### bench/integer_decimal_field_formatter_top_test.sv
module integer_decimal_field_formatter_top_test;

   // drive every input to a known level from time zero
   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [63:0]       req_raw_value    = '0;
   logic              req_is_signed    = 1'b0;
   logic [2:0]        req_size_code    = '0;
   logic [5:0]        req_field_width  = '0;
   logic signed [6:0] req_precision    = '0;
   logic [5:0]        req_format_flags = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [7:0]        rsp_out_char;
   logic              rsp_last_char;

   int char_mismatches;
   int chars_pending;

   // idling odds, in percent, for each side
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   // bump to ask the receiver for one long hold-off
   int long_hold_count = 0;

   always #1 clock = ~clock;

   integer_decimal_field_formatter_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_value    (req_raw_value),
      .req_is_signed    (req_is_signed),
      .req_size_code    (req_size_code),
      .req_field_width  (req_field_width),
      .req_precision    (req_precision),
      .req_format_flags (req_format_flags),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char)
   );

   idf_field_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_value    (req_raw_value),
      .req_is_signed    (req_is_signed),
      .req_size_code    (req_size_code),
      .req_field_width  (req_field_width),
      .req_precision    (req_precision),
      .req_format_flags (req_format_flags),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char),
      .char_mismatches  (char_mismatches),
      .chars_pending    (chars_pending)
   );

   // Offer one request. Entered and left at a falling edge; valid is written
   // once per step, so a back-to-back transfer keeps it high throughout.
   task automatic send_request(input logic [63:0] raw_value, input logic is_signed,
                               input logic [2:0] size_code, input int field_width,
                               input int precision, input logic [5:0] flags);
      // idle first, at random
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_raw_value    = raw_value;
      req_is_signed    = is_signed;
      req_size_code    = size_code;
      req_field_width  = 6'(field_width);
      req_precision    = 7'(precision);
      req_format_flags = flags;
      // hold the payload until the transfer completes
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Mix small values, full-width noise and the size boundaries.
   function automatic logic [63:0] pick_raw_value();
      case ($urandom_range(5))
         0: return 64'($urandom_range(99));
         1: return {$urandom, $urandom};
         2: begin
            case ($urandom_range(9))
               0: return 64'h0000_0000_0000_0000;
               1: return 64'h0000_0000_0000_007F;
               2: return 64'h0000_0000_0000_0080;
               3: return 64'h0000_0000_0000_7FFF;
               4: return 64'h0000_0000_0000_8000;
               5: return 64'h0000_0000_7FFF_FFFF;
               6: return 64'h0000_0000_8000_0000;
               7: return 64'h7FFF_FFFF_FFFF_FFFF;
               8: return 64'h8000_0000_0000_0000;
               default: return 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
         end
         3: return {$urandom, 32'($urandom_range(99999))};
         4: return 64'd0 - 64'($urandom_range(1, 9999));
         default: return 64'($urandom);
      endcase
   endfunction

   task automatic send_random_requests(input int count);
      int field_width;
      int precision;
      repeat (count) begin
         // mostly modest widths; now and then up to the port limit to hit saturation
         field_width = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(24);
         case ($urandom_range(5))
            0, 1: precision = -1;
            2:    precision = -int'($urandom_range(2, 64));
            3:    precision = 0;
            4:    precision = $urandom_range(63);
            default: precision = $urandom_range(12);
         endcase
         send_request(pick_raw_value(), 1'($urandom_range(1)), 3'($urandom_range(7)),
                      field_width, precision, 6'($urandom_range(63)));
      end
   endtask

   // Receiver: stall at random, or hold off for a long stretch when asked.
   initial begin : receiver
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      forever begin
         @(negedge clock);
         if (long_hold_count != holds_seen) begin
            holds_seen = long_hold_count;
            hold_left  = 400;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sender busy, receiver sparse
      req_idle_pct = 31;
      rsp_idle_pct = 74;

      // directed: empty field, plain zero, size boundaries
      send_request(64'd0, 1'b1, 3'd0, 0, 0, 6'h00);
      send_request(64'd0, 1'b0, 3'd0, 0, -1, 6'h00);
      send_request(64'h0000_0000_8000_0000, 1'b1, 3'd0, 0, -1, 6'h00);
      send_request(64'h8000_0000_0000_0000, 1'b1, 3'd3, 0, -1, 6'h00);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 3'd4, 0, -1, 6'h00);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'd5, 0, -1, 6'h00);
      send_request(64'hAAAA_5555_1234_5680, 1'b1, 3'd1, 0, -1, 6'h00);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 3'd1, 0, -1, 6'h00);
      send_request(64'h1234_5678_0000_8000, 1'b1, 3'd2, 0, -1, 6'h00);
      send_request(64'h1234_5678_1234_7FFF, 1'b1, 3'd2, 0, -1, 6'h00);
      // sign flags, and a plus flag on an unsigned conversion
      send_request(64'd42, 1'b1, 3'd6, 0, -1, 6'h10);
      send_request(64'd42, 1'b1, 3'd7, 0, -1, 6'h04);
      send_request(64'd42, 1'b1, 3'd0, 0, -1, 6'h14);
      send_request(64'd42, 1'b0, 3'd0, 0, -1, 6'h14);
      // zero fill: plain, under a precision, and beaten by left align
      send_request(64'd0 - 64'd7, 1'b1, 3'd3, 10, -1, 6'h08);
      send_request(64'd123, 1'b1, 3'd0, 12, 5, 6'h18);
      send_request(64'd123, 1'b1, 3'd0, 12, 5, 6'h28);
      send_request(64'd99, 1'b0, 3'd0, 9, -1, 6'h20);
      // saturation of width and precision, odd negative precisions
      send_request(64'd5, 1'b1, 3'd0, 63, -1, 6'h00);
      send_request(64'd5, 1'b1, 3'd0, 0, 63, 6'h00);
      send_request(64'd5, 1'b1, 3'd0, 4, -2, 6'h08);
      send_request(64'd0, 1'b1, 3'd0, 3, -64, 6'h00);
      // zero at precision zero with a sign, or with width only
      send_request(64'd0, 1'b1, 3'd0, 0, 0, 6'h10);
      send_request(64'd0, 1'b0, 3'd0, 5, 0, 6'h03);
      // longest field: sign plus forty digits
      send_request(64'd0 - 64'd1, 1'b1, 3'd0, 40, 40, 6'h3F);

      send_random_requests(30);

      // sender sparse, receiver busy
      req_idle_pct = 74;
      rsp_idle_pct = 31;
      send_random_requests(35);

      // no idling on either side
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random_requests(20);
      // hold off the receiver while requests keep coming, to back the block up
      long_hold_count++;
      send_random_requests(20);

      req_valid = 1'b0;

      // drain, then allow for a request still in flight that yields nothing
      while (chars_pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      if (char_mismatches == 0 && chars_pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
design/idf_pkg.sv
design/idf_bcd.sv
design/idf_emit.sv
design/integer_decimal_field_formatter_top.sv
bench/idf_field_checker.sv
bench/integer_decimal_field_formatter_top_test.sv
